// ===== rtl/core/i2c_master_register_transfer_assert.svh =====
// assertion macros for the i2c register transfer master
// used by modules that check their own state, needs clk_i and rst_ni in scope
`ifndef I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
// types and constants shared by the i2c register transfer master
// no dependencies
package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_A   = 5'd1,
    PH_ST_B   = 5'd2,
    PH_ST_C   = 5'd3,
    PH_TX_HI  = 5'd4,
    PH_TX_LO  = 5'd5,
    PH_AK_REL = 5'd6,
    PH_AK_HI  = 5'd7,
    PH_AK_LO  = 5'd8,
    PH_WAIT   = 5'd9,
    PH_RX_REL = 5'd10,
    PH_RX_HI  = 5'd11,
    PH_RX_LO  = 5'd12,
    PH_NK_HI  = 5'd13,
    PH_NK_LO  = 5'd14,
    PH_SP_A   = 5'd15,
    PH_SP_B   = 5'd16,
    PH_SP_C   = 5'd17
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ADDR  = 2'd0,
    KIND_REG   = 2'd1,
    KIND_RADDR = 2'd2,
    KIND_DATA  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_BYTE  = 2'd3
  } cmd_e;

  localparam logic [2:0]  LastBit     = 3'd7;
  localparam logic [15:0] HalfDefault = 16'd1;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  bit_index;
    logic [7:0]  shift_byte;
    logic [7:0]  bytes_left;
    logic [15:0] phase_timer;
    logic        reading;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [7:0]  pending_byte;
    logic        pending_valid;
    kind_e       byte_kind;
  } eng_state_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       scl_sample;
    logic       sda_sample;
  } eng_in_t;

  typedef struct packed {
    logic       done_res;
    logic       busy_res;
    logic       need_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       sda_release;
    logic       scl_release;
  } eng_out_t;

endpackage

// ===== rtl/core/i2cm_engine.sv =====
// next-state and line-level logic for one bus tick of the i2c master
// depends on i2cm_pkg
module i2cm_engine import i2cm_pkg::*; (
  input  eng_state_t  st_i,
  input  eng_in_t     in_i,
  input  logic [15:0] half_period_i,
  output eng_state_t  st_o,
  output eng_out_t    res_o
);

  eng_state_t  s;
  eng_state_t  n;
  eng_out_t    r;
  logic [15:0] hp;
  logic        nack;
  logic        expired;

  assign hp      = (half_period_i == '0) ? HalfDefault : half_period_i;
  assign expired = !(({1'b0, s.phase_timer} + 17'd1) < {1'b0, hp});

  always_comb begin
    s = st_i;
    // command first
    if (s.phase == PH_IDLE && (in_i.cmd == CMD_READ || in_i.cmd == CMD_WRITE)) begin
      s.dev_addr      = in_i.device_address;
      s.reg_addr      = in_i.register_address;
      s.bytes_left    = in_i.byte_count;
      s.reading       = (in_i.cmd == CMD_READ);
      s.pending_valid = 1'b0;
      s.byte_kind     = KIND_ADDR;
      s.bit_index     = '0;
      s.phase         = PH_ST_A;
      s.phase_timer   = '0;
    end else if (in_i.cmd == CMD_BYTE && s.phase != PH_IDLE && !s.reading &&
                 !s.pending_valid) begin
      s.pending_byte  = in_i.write_byte;
      s.pending_valid = 1'b1;
    end
  end

  assign nack = (s.bytes_left == '0);

  always_comb begin
    n = s;
    r = '0;
    r.scl_release = 1'b1;
    r.sda_release = 1'b1;
    unique case (s.phase)
      PH_ST_B:  r.sda_release = 1'b0;
      PH_ST_C, PH_SP_A: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
      end
      PH_TX_HI: r.sda_release = s.shift_byte[7];
      PH_TX_LO: begin
        r.scl_release = 1'b0;
        r.sda_release = s.shift_byte[7];
      end
      PH_AK_REL, PH_AK_LO, PH_WAIT, PH_RX_REL, PH_RX_LO: r.scl_release = 1'b0;
      PH_NK_HI: r.sda_release = nack;
      PH_NK_LO: begin
        r.scl_release = 1'b0;
        r.sda_release = nack;
      end
      PH_SP_B:  r.sda_release = 1'b0;
      default: ;
    endcase
    r.busy_res  = (s.phase != PH_IDLE);
    r.need_byte = (s.phase == PH_WAIT) && !s.pending_valid;

    if (s.phase == PH_WAIT) begin
      if (s.pending_valid) begin
        n.pending_valid = 1'b0;
        n.bytes_left    = s.bytes_left - 8'd1;
        n.byte_kind     = KIND_DATA;
        n.shift_byte    = s.pending_byte;
        n.bit_index     = '0;
        n.phase         = PH_TX_HI;
        n.phase_timer   = '0;
      end
    end else if (s.phase != PH_IDLE) begin
      if (!expired) begin
        n.phase_timer = s.phase_timer + 16'd1;
      end else begin
        n.phase_timer = '0;
        unique case (s.phase)
          PH_ST_A: n.phase = PH_ST_B;
          PH_ST_B: n.phase = PH_ST_C;
          PH_ST_C: begin
            n.bit_index = '0;
            n.phase     = PH_TX_HI;
            if (s.byte_kind == KIND_RADDR) begin
              n.byte_kind  = KIND_RADDR;
              n.shift_byte = s.dev_addr | 8'h01;
            end else begin
              n.byte_kind  = KIND_ADDR;
              n.shift_byte = s.dev_addr;
            end
          end
          PH_TX_HI: n.phase = PH_TX_LO;
          PH_TX_LO: begin
            if (s.bit_index == LastBit) begin
              n.phase = PH_AK_REL;
            end else begin
              n.bit_index  = s.bit_index + 3'd1;
              n.shift_byte = {s.shift_byte[6:0], 1'b0};
              n.phase      = PH_TX_HI;
            end
          end
          PH_AK_REL: n.phase = PH_AK_HI;
          PH_AK_HI:  n.phase = PH_AK_LO;
          PH_AK_LO: begin
            priority if (s.byte_kind == KIND_ADDR) begin
              n.byte_kind  = KIND_REG;
              n.shift_byte = s.reg_addr;
              n.bit_index  = '0;
              n.phase      = PH_TX_HI;
            end else if (s.byte_kind == KIND_REG && s.reading) begin
              n.byte_kind = KIND_RADDR;
              n.phase     = PH_ST_A;
            end else if (s.byte_kind == KIND_RADDR) begin
              if (!nack) begin
                n.bytes_left = s.bytes_left - 8'd1;
                n.phase      = PH_RX_REL;
              end else begin
                n.phase = PH_SP_A;
              end
            end else begin
              n.phase = nack ? PH_SP_A : PH_WAIT;
            end
          end
          PH_RX_REL: begin
            n.bit_index  = '0;
            n.shift_byte = '0;
            n.phase      = PH_RX_HI;
          end
          PH_RX_HI: begin
            if (in_i.scl_sample) begin
              n.shift_byte = {s.shift_byte[6:0], in_i.sda_sample};
              if (s.bit_index == LastBit) begin
                r.read_valid = 1'b1;
                r.read_byte  = {s.shift_byte[6:0], in_i.sda_sample};
              end
              n.phase = PH_RX_LO;
            end else begin
              // clock stretched by the slave
              n.phase_timer = s.phase_timer;
            end
          end
          PH_RX_LO: begin
            if (s.bit_index == LastBit) begin
              n.phase = PH_NK_HI;
            end else begin
              n.bit_index = s.bit_index + 3'd1;
              n.phase     = PH_RX_HI;
            end
          end
          PH_NK_HI: n.phase = PH_NK_LO;
          PH_NK_LO: begin
            if (!nack) begin
              n.bytes_left = s.bytes_left - 8'd1;
              n.phase      = PH_RX_REL;
            end else begin
              n.phase = PH_SP_A;
            end
          end
          PH_SP_A: n.phase = PH_SP_B;
          PH_SP_B: n.phase = PH_SP_C;
          PH_SP_C: begin
            r.done_res      = 1'b1;
            n.pending_valid = 1'b0;
            n.phase         = PH_IDLE;
          end
          default: n.phase = PH_IDLE;
        endcase
      end
    end
  end

  assign st_o  = n;
  assign res_o = r;

endmodule

// ===== rtl/core/i2c_master_register_transfer.sv =====
// top level of the i2c register transfer master: stream ports, state and result registers
// depends on i2cm_pkg, i2cm_engine and i2c_master_register_transfer_assert.svh
//
// Each input transaction on the s_axis channel is one tick of bus time: it carries a
// command (tuser) plus the sampled scl/sda levels and transfer arguments (tdata).
// For every accepted input transaction exactly one result transaction leaves on the
// m_axis channel, holding the scl/sda release levels to drive for that tick, a
// received byte with its valid flag, and need_byte/busy/done status.
// The result is registered at acceptance and offered on m_axis in the cycle after.
// Throughput: one transaction per cycle while the receiver keeps up; the tick logic is
// a single pass from the state register to the result register. Each bus phase but the
// write wait lasts at least half_period_ticks input transactions (0 acts as 1). The
// user must write it through the cfg channel only while no transfer runs; the block does
// not enforce this, and cfg_ready_o is always high. Reset puts the engine idle with both
// lines released and half_period_ticks at 1. When the receiver stalls, the result is
// held and s_axis_tready_o drops, so no tick is taken until the pending result leaves.
`include "i2c_master_register_transfer_assert.svh"

module i2c_master_register_transfer import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,        // half_period_ticks
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // device_address, register_address, byte_count, write_byte, scl_sample, sda_sample
  input  logic [39:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,    // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // scl_release, sda_release, read_byte, read_valid, need_byte, busy_res, done_res
  output logic [15:0] m_axis_tdata_o
);

  eng_state_t  st_q, st_d;
  eng_in_t     ein;
  eng_out_t    res_d, res_q;
  logic [15:0] half_q;
  logic        m_valid_q;
  logic        in_acc;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign ein.cmd              = cmd_e'(s_axis_tuser_i);
  assign ein.device_address   = s_axis_tdata_i[7:0];
  assign ein.register_address = s_axis_tdata_i[15:8];
  assign ein.byte_count       = s_axis_tdata_i[23:16];
  assign ein.write_byte       = s_axis_tdata_i[31:24];
  assign ein.scl_sample       = s_axis_tdata_i[32];
  assign ein.sda_sample       = s_axis_tdata_i[33];

  i2cm_engine u_engine (
    .st_i          (st_q),
    .in_i          (ein),
    .half_period_i (half_q),
    .st_o          (st_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      half_q     <= HalfDefault;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        half_q <= cfg_data_i;
      end
      if (in_acc) begin
        st_q      <= st_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q};

  `I2CM_ASSERT_NOW(a_read_while_busy, m_valid_q && res_q.read_valid, res_q.busy_res,
                   "read byte reported outside a transfer")
  `I2CM_ASSERT_NOW(a_done_while_busy, m_valid_q && res_q.done_res, res_q.busy_res,
                   "stop completion reported outside a transfer")
  `I2CM_ASSERT_NOW(a_need_holds_scl, m_valid_q && res_q.need_byte, !res_q.scl_release,
                   "clock released while waiting for a write byte")
  `I2CM_ASSERT_NOW(a_idle_no_pending, st_q.phase == PH_IDLE, !st_q.pending_valid,
                   "write byte pending while idle")
  `I2CM_ASSERT_NEXT(a_stall_holds, m_valid_q && !m_axis_tready_i,
                    m_valid_q && $stable(res_q), "result changed while the receiver stalled")

endmodule

// ===== tb/tb_i2c_master_register_transfer.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the i2c register transfer master: streams bus ticks,
// predicts every result with its own phase engine and compares each field in order
// depends on i2cm_pkg and the i2c_master_register_transfer rtl
module tb_i2c_master_register_transfer;
  import i2cm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  i2c_master_register_transfer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bus engine shadow
  phase_e      bus_phase = PH_IDLE;
  kind_e       byte_kind = KIND_ADDR;
  logic [2:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [7:0]  bytes_remaining = '0;
  logic [15:0] phase_ticks = '0;
  logic        is_read = 1'b0;
  logic [7:0]  dev_addr = '0;
  logic [7:0]  reg_addr = '0;
  logic [7:0]  wr_byte_buf = '0;
  logic        wr_byte_held = 1'b0;
  logic [15:0] half_period = HalfDefault;

  eng_in_t  bus_ticks[$];
  eng_out_t expected_results[$];
  logic     tick_taken = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_req = 1'b0;
  int       hold_cycles = 0;
  int       errors = 0;
  int       n_ticks = 0;
  int       n_read_bytes = 0;
  int       n_stops = 0;
  int       n_settings = 0;

  function automatic void enter(input phase_e p);
    bus_phase = p;
    phase_ticks = '0;
  endfunction

  function automatic void load_tx(input kind_e k, input logic [7:0] value);
    byte_kind = k;
    shreg = value;
    bit_cnt = '0;
    enter(PH_TX_HI);
  endfunction

  function automatic void next_rx();
    bytes_remaining = bytes_remaining - 8'd1;
    enter(PH_RX_REL);
  endfunction

  function automatic eng_out_t step_engine(input eng_in_t t);
    eng_out_t r;
    logic nack;
    int hp;
    r = '0;
    r.scl_release = 1'b1;
    r.sda_release = 1'b1;
    if (bus_phase == PH_IDLE && (t.cmd == CMD_READ || t.cmd == CMD_WRITE)) begin
      dev_addr = t.device_address;
      reg_addr = t.register_address;
      bytes_remaining = t.byte_count;
      is_read = (t.cmd == CMD_READ);
      wr_byte_held = 1'b0;
      byte_kind = KIND_ADDR;
      bit_cnt = '0;
      enter(PH_ST_A);
    end else if (t.cmd == CMD_BYTE && bus_phase != PH_IDLE && !is_read && !wr_byte_held) begin
      wr_byte_buf = t.write_byte;
      wr_byte_held = 1'b1;
    end

    nack = (bytes_remaining == 8'd0);
    case (bus_phase)
      PH_ST_B: r.sda_release = 1'b0;
      PH_ST_C, PH_SP_A: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
      end
      PH_TX_HI: r.sda_release = shreg[7];
      PH_TX_LO: begin
        r.scl_release = 1'b0;
        r.sda_release = shreg[7];
      end
      PH_AK_REL, PH_AK_LO, PH_WAIT, PH_RX_REL, PH_RX_LO: r.scl_release = 1'b0;
      PH_NK_HI: r.sda_release = nack;
      PH_NK_LO: begin
        r.scl_release = 1'b0;
        r.sda_release = nack;
      end
      PH_SP_B: r.sda_release = 1'b0;
      default: ;
    endcase
    r.busy_res = (bus_phase != PH_IDLE);
    r.need_byte = (bus_phase == PH_WAIT) && !wr_byte_held;

    hp = (half_period == 16'd0) ? 1 : int'(half_period);
    if (bus_phase == PH_WAIT) begin
      if (wr_byte_held) begin
        wr_byte_held = 1'b0;
        bytes_remaining = bytes_remaining - 8'd1;
        load_tx(KIND_DATA, wr_byte_buf);
      end
    end else if (bus_phase != PH_IDLE) begin
      if (int'(phase_ticks) + 1 < hp) begin
        phase_ticks = phase_ticks + 16'd1;
      end else begin
        case (bus_phase)
          PH_ST_A: enter(PH_ST_B);
          PH_ST_B: enter(PH_ST_C);
          PH_ST_C: begin
            if (byte_kind == KIND_RADDR) load_tx(KIND_RADDR, dev_addr | 8'h01);
            else load_tx(KIND_ADDR, dev_addr);
          end
          PH_TX_HI: enter(PH_TX_LO);
          PH_TX_LO: begin
            if (bit_cnt == LastBit) begin
              enter(PH_AK_REL);
            end else begin
              bit_cnt = bit_cnt + 3'd1;
              shreg = {shreg[6:0], 1'b0};
              enter(PH_TX_HI);
            end
          end
          PH_AK_REL: enter(PH_AK_HI);
          PH_AK_HI: enter(PH_AK_LO);
          PH_AK_LO: begin
            if (byte_kind == KIND_ADDR) begin
              load_tx(KIND_REG, reg_addr);
            end else if (byte_kind == KIND_REG && is_read) begin
              byte_kind = KIND_RADDR;
              enter(PH_ST_A);
            end else if (byte_kind == KIND_RADDR) begin
              if (bytes_remaining != 8'd0) next_rx();
              else enter(PH_SP_A);
            end else begin
              enter((bytes_remaining != 8'd0) ? PH_WAIT : PH_SP_A);
            end
          end
          PH_RX_REL: begin
            bit_cnt = '0;
            shreg = '0;
            enter(PH_RX_HI);
          end
          PH_RX_HI: begin
            // clock stretching holds this phase until scl reads high
            if (t.scl_sample) begin
              shreg = {shreg[6:0], t.sda_sample};
              if (bit_cnt == LastBit) begin
                r.read_valid = 1'b1;
                r.read_byte = shreg;
              end
              enter(PH_RX_LO);
            end
          end
          PH_RX_LO: begin
            if (bit_cnt == LastBit) begin
              enter(PH_NK_HI);
            end else begin
              bit_cnt = bit_cnt + 3'd1;
              enter(PH_RX_HI);
            end
          end
          PH_NK_HI: enter(PH_NK_LO);
          PH_NK_LO: begin
            if (bytes_remaining != 8'd0) next_rx();
            else enter(PH_SP_A);
          end
          PH_SP_A: enter(PH_SP_B);
          PH_SP_B: enter(PH_SP_C);
          PH_SP_C: begin
            r.done_res = 1'b1;
            wr_byte_held = 1'b0;
            enter(PH_IDLE);
          end
          default: enter(PH_IDLE);
        endcase
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h (tick %0d)", name, want, got, n_ticks);
      errors++;
    end
  endtask

  // sender
  always @(negedge clk_i) begin : sender
    eng_in_t t;
    logic popped;
    logic nxt_valid;
    popped = 1'b0;
    if (tick_taken) begin
      t = bus_ticks.pop_front();
      tick_taken = 1'b0;
      popped = 1'b1;
    end
    nxt_valid = s_axis_tvalid_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!s_axis_tvalid_i || popped) begin
      nxt_valid = 1'b0;
      if (bus_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        t = bus_ticks[0];
        s_axis_tdata_i <= {6'd0, t.sda_sample, t.scl_sample, t.write_byte, t.byte_count,
                           t.register_address, t.device_address};
        s_axis_tuser_i <= t.cmd;
        nxt_valid = 1'b1;
      end
    end
    s_axis_tvalid_i <= nxt_valid;
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk_i) begin : receiver
    if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cycles = 300;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    eng_in_t t;
    eng_out_t want;
    eng_out_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        t.cmd = cmd_e'(s_axis_tuser_i);
        {t.sda_sample, t.scl_sample, t.write_byte, t.byte_count, t.register_address,
         t.device_address} = s_axis_tdata_i[33:0];
        expected_results.push_back(step_engine(t));
        tick_taken = 1'b1;
        n_ticks++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = eng_out_t'(m_axis_tdata_o[13:0]);
        if (expected_results.size() == 0) begin
          $error("result transaction with no tick outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("scl_release", want.scl_release, got.scl_release);
          check_field("sda_release", want.sda_release, got.sda_release);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("read_valid", want.read_valid, got.read_valid);
          check_field("need_byte", want.need_byte, got.need_byte);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          if (got.read_valid) n_read_bytes++;
          if (got.done_res) n_stops++;
        end
      end
    end
  end

  function automatic eng_in_t mk_tick(input cmd_e cmd, input logic [7:0] dev,
                                      input logic [7:0] rega, input logic [7:0] cnt,
                                      input logic [7:0] wb, input logic scl,
                                      input logic sda);
    eng_in_t t;
    t.cmd = cmd;
    t.device_address = dev;
    t.register_address = rega;
    t.byte_count = cnt;
    t.write_byte = wb;
    t.scl_sample = scl;
    t.sda_sample = sda;
    return t;
  endfunction

  function automatic eng_in_t rand_tick(input cmd_e cmd);
    return mk_tick(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom), 1'($urandom));
  endfunction

  task automatic drain();
    while (bus_ticks.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // finish any open transfer with scl high, feeding write bytes as asked
  task automatic settle();
    eng_in_t t;
    drain();
    while (bus_phase != PH_IDLE) begin
      repeat (64) begin
        t = rand_tick(CMD_BYTE);
        t.scl_sample = 1'b1;
        bus_ticks.push_back(t);
      end
      drain();
    end
  endtask

  task automatic write_half(input logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    half_period = v;
    n_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_transfer(input bit rd, input int count);
    eng_in_t t;
    int hp;
    int span;
    hp = (half_period == 16'd0) ? 1 : int'(half_period);
    span = (rd ? 85 + 19 * count : 44 + 20 * count) * hp + 8 * count + 16;
    t = rand_tick(rd ? CMD_READ : CMD_WRITE);
    t.byte_count = 8'(count);
    bus_ticks.push_back(t);
    for (int i = 0; i < span; i++) begin
      if (rd) t = rand_tick(($urandom_range(15) == 0) ? CMD_BYTE : CMD_TICK);
      else t = rand_tick(($urandom_range(3) == 0) ? CMD_BYTE : CMD_TICK);
      t.scl_sample = ($urandom_range(7) != 0);
      // begin requests while busy must be ignored
      if (i < span / 2 && $urandom_range(39) == 0)
        t.cmd = ($urandom_range(1) != 0) ? CMD_READ : CMD_WRITE;
      bus_ticks.push_back(t);
    end
    repeat (4 * hp + 4) bus_ticks.push_back(rand_tick(CMD_TICK));
  endtask

  task automatic random_traffic(input int n);
    int start;
    int r;
    start = bus_ticks.size() + n_ticks;
    while (bus_ticks.size() + n_ticks < start + n) begin
      if ($urandom_range(7) == 0)
        repeat ($urandom_range(6, 1))
          bus_ticks.push_back(rand_tick(($urandom_range(1) != 0) ? CMD_BYTE : CMD_TICK));
      r = $urandom_range(19);
      run_transfer($urandom_range(1), (r < 14) ? $urandom_range(3) : $urandom_range(10, 4));
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin : timeout
    #10_000_000;
    $display("i2c_master_register_transfer regression: fail");
    $finish;
  end

  initial begin : main
    eng_in_t t;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle strays, field extremes, every command
    bus_ticks.push_back(mk_tick(CMD_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    bus_ticks.push_back(mk_tick(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    bus_ticks.push_back(mk_tick(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    bus_ticks.push_back(mk_tick(CMD_WRITE, 8'hFF, 8'h00, 8'h01, 8'h00, 1'b1, 1'b1));
    bus_ticks.push_back(mk_tick(CMD_READ, 8'h00, 8'hFF, 8'h05, 8'h00, 1'b1, 1'b1));
    bus_ticks.push_back(mk_tick(CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'hA5, 1'b1, 1'b1));
    bus_ticks.push_back(mk_tick(CMD_BYTE, 8'h00, 8'h00, 8'h00, 8'h3C, 1'b1, 1'b1));
    settle();
    bus_ticks.push_back(mk_tick(CMD_READ, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1));
    settle();
    bus_ticks.push_back(mk_tick(CMD_WRITE, 8'h80, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0));
    settle();
    bus_ticks.push_back(mk_tick(CMD_READ, 8'hA4, 8'h5B, 8'h02, 8'h00, 1'b1, 1'b0));
    repeat (40) bus_ticks.push_back(mk_tick(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                                            1'b1, 1'b1));
    repeat (6) bus_ticks.push_back(mk_tick(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                                           1'b0, 1'b1));
    settle();

    // zero half period acts as one
    write_half(16'd0);
    random_traffic(100);
    settle();

    write_half(16'd2);
    set_idling(83, 0);
    random_traffic(100);
    settle();

    // long receiver hold-off stalls the block while the sender keeps offering ticks
    write_half(16'd3);
    set_idling(0, 83);
    hold_req = 1'b1;
    random_traffic(100);
    settle();

    // sender pauses midway until all results are back
    write_half(16'd1);
    set_idling(20, 20);
    random_traffic(50);
    drain();
    random_traffic(50);
    settle();

    // widest half period: the first phase of a transfer only counts
    write_half(16'hFFFF);
    set_idling(20, 20);
    repeat (20) bus_ticks.push_back(rand_tick(($urandom_range(1) != 0) ? CMD_BYTE : CMD_TICK));
    t = rand_tick(CMD_READ);
    t.byte_count = 8'hFF;
    bus_ticks.push_back(t);
    repeat (100) bus_ticks.push_back(rand_tick(($urandom_range(1) != 0) ? CMD_BYTE : CMD_TICK));
    drain();
    repeat (20) @(posedge clk_i);

    $display("ran %0d bus ticks over %0d half-period settings", n_ticks, n_settings);
    $display("saw %0d received bytes and %0d completed stop conditions", n_read_bytes,
             n_stops);
    if (errors == 0) begin
      $display("i2c_master_register_transfer regression: pass");
    end else begin
      $display("i2c_master_register_transfer regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_engine.sv
rtl/core/i2c_master_register_transfer.sv
tb/tb_i2c_master_register_transfer.sv
